FILE: rtl/core/ftws_pkg.sv
package ftws_pkg;

	// Ring depth: frames in the averaging window
	localparam int WINDOW = 60;

	localparam int STAMP_W  = 32;
	localparam int DELTA_W  = 24;
	localparam int SUM_W    = 30;
	localparam int ACCUM_W  = 25;
	localparam int RATE_W   = 24;
	localparam int PERIOD_W = 24;
	localparam int THRESH_W = 16;
	localparam int FRAC_W   = 8;

	localparam int SLOT_W = $clog2(WINDOW);
	localparam int SCAN_W = $clog2(WINDOW + 1);

	// Rate numerator: WINDOW frames * 256 (Q8) * 1e6 us/s
	localparam logic [63:0] RATE_SCALE   = 64'd256000000;
	localparam logic [63:0] RATE_DIVIDEND = 64'(WINDOW) * RATE_SCALE;
	localparam int          DIV_W        = $clog2(RATE_DIVIDEND + 64'd1);
	localparam int          DIV_CNT_W    = $clog2(DIV_W + 1);

	localparam logic [DELTA_W-1:0] DELTA_MAX = '1;
	localparam logic [RATE_W-1:0]  RATE_MAX  = '1;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd500000;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd30;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 24;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_REFRESH_PERIOD = 2'd0,
		REG_GOOD_THRESHOLD = 2'd1
	} cfg_reg_t;

endpackage

FILE: rtl/core/ftws_in_if.sv
interface ftws_in_if;
	import ftws_pkg::*;

	logic               valid;
	logic               ready;
	logic [STAMP_W-1:0] timestamp_us;

	modport source (output valid, output timestamp_us, input ready);
	modport sink   (input valid, input timestamp_us, output ready);
endinterface

FILE: rtl/core/ftws_out_if.sv
interface ftws_out_if;
	import ftws_pkg::*;

	logic              valid;
	logic              ready;
	logic [RATE_W-1:0] shown_rate_q8;
	logic [DELTA_W-1:0] shown_max_us;
	logic [DELTA_W-1:0] shown_min_us;
	logic              rate_good;
	logic              refreshed;

	modport source (output valid, output shown_rate_q8, output shown_max_us,
		output shown_min_us, output rate_good, output refreshed, input ready);
	modport sink   (input valid, input shown_rate_q8, input shown_max_us,
		input shown_min_us, input rate_good, input refreshed, output ready);
endinterface

FILE: rtl/core/ftws_cfg_if.sv
interface ftws_cfg_if;
	import ftws_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/frame_time_window_stats_core.sv
// Frame time window statistics.
// stamp : one transaction per frame carrying its free-running microsecond
//         timestamp. Ready is high only while the core is idle.
// stats : exactly one transaction per stamp transaction, carrying the latched
//         rate (Q8 frames/s), window min/max frame time, rate_good and a
//         refreshed flag that marks the frame which latched new values.
// cfg   : register writes, always ready. Index 0 is the refresh period in us,
//         index 1 the good-rate threshold in whole frames/s. Other indexes
//         are dropped. Write only while the core is idle.
// Flow: after accept the ring entry and sum are updated, then the min/max
// scan reads the delta ring's read port one entry per cycle and sets the
// time from accept to result; the 34-step rate divider runs alongside it.
// One frame is worked through at a time; the next frame is taken the cycle
// after the result is loaded.
// Result is held in an output register; if the receiver stalls, one more
// frame is taken and worked through, then the core holds in its final state
// with the input not ready until the held result leaves.
// Reset: ring valid bits cleared (unwritten entries read as zero), sums,
// accumulator and latched values zeroed, registers back to their defaults.
module frame_time_window_stats_core (
	input  logic               clk,
	input  logic               arst_n,
	ftws_in_if.sink            stamp,
	ftws_out_if.source         stats,
	ftws_cfg_if.sink           cfg
);
	import ftws_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SCAN,
		ST_DIV_WAIT,
		ST_FINISH
	} state_t;

	state_t state_q;

	// configuration
	logic [PERIOD_W-1:0] period_q;
	logic [THRESH_W-1:0] thresh_q;

	// frame state
	logic [STAMP_W-1:0] prev_stamp_q;
	logic               primed_q;
	logic [DELTA_W-1:0] delta_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [SUM_W-1:0]   sum_q;
	logic [ACCUM_W-1:0] accum_q;
	logic [RATE_W-1:0]  lat_rate_q;
	logic [DELTA_W-1:0] lat_max_q;
	logic [DELTA_W-1:0] lat_min_q;

	// ring memory and its entry-valid bits
	logic [DELTA_W-1:0] ring_mem [WINDOW];
	logic [WINDOW-1:0]  ring_vld_q;
	logic [DELTA_W-1:0] rd_data_s1;
	logic               rd_vld_s1;
	logic               rd_en;
	logic [SLOT_W-1:0]  rd_addr;
	logic               wr_en;

	// scan
	logic [SCAN_W-1:0]  scan_idx_q;
	logic [DELTA_W-1:0] scan_min_q;
	logic [DELTA_W-1:0] scan_max_q;

	// restoring divider
	logic [SUM_W-1:0]     divisor_q;
	logic [SUM_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	// output register
	logic               out_vld_q;
	logic [RATE_W-1:0]  out_rate_q;
	logic [DELTA_W-1:0] out_max_q;
	logic [DELTA_W-1:0] out_min_q;
	logic               out_good_q;
	logic               out_refr_q;

	// combinational
	logic               stamp_fire;
	logic [STAMP_W-1:0] stamp_diff;
	logic [DELTA_W-1:0] new_delta;
	logic [DELTA_W-1:0] old_delta;
	logic [SUM_W-1:0]   sum_next;
	logic [DELTA_W-1:0] scan_val;
	logic [SUM_W:0]     div_shift;
	logic               div_take;
	logic [RATE_W-1:0]  rate_val;
	logic               refresh_hit;
	logic [RATE_W-1:0]  rate_pick;
	logic               out_free;

	assign stamp.ready = (state_q == ST_IDLE);
	assign stamp_fire  = stamp.valid && stamp.ready;
	assign cfg.ready   = 1'b1;

	assign stats.valid         = out_vld_q;
	assign stats.shown_rate_q8 = out_rate_q;
	assign stats.shown_max_us  = out_max_q;
	assign stats.shown_min_us  = out_min_q;
	assign stats.rate_good     = out_good_q;
	assign stats.refreshed     = out_refr_q;

	// Frame delta, wrap-safe, saturated to 24 bits; zero on the first frame
	assign stamp_diff = stamp.timestamp_us - prev_stamp_q;
	always_comb begin
		if (!primed_q)
			new_delta = '0;
		else if (|stamp_diff[STAMP_W-1:DELTA_W])
			new_delta = DELTA_MAX;
		else
			new_delta = stamp_diff[DELTA_W-1:0];
	end

	// Ring read port: old entry at accept, then the scan sweep
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = slot_q;
		if (state_q == ST_IDLE) begin
			rd_en   = stamp_fire;
			rd_addr = slot_q;
		end else if (state_q == ST_SCAN) begin
			rd_en   = (scan_idx_q < SCAN_W'(WINDOW));
			rd_addr = scan_idx_q[SLOT_W-1:0];
		end
	end

	assign wr_en     = (state_q == ST_UPDATE);
	assign old_delta = rd_vld_s1 ? rd_data_s1 : '0;
	assign scan_val  = rd_vld_s1 ? rd_data_s1 : '0;
	// Window sum: drop the overwritten delta, add the new one (mod 2^30)
	assign sum_next  = sum_q - SUM_W'(old_delta) + SUM_W'(delta_q);

	// One quotient bit per cycle
	assign div_shift = {rem_q, quo_q[DIV_W-1]};
	assign div_take  = (div_shift >= {1'b0, divisor_q});

	always_comb begin
		if (divisor_q == '0 || |quo_q[DIV_W-1:RATE_W])
			rate_val = RATE_MAX;
		else
			rate_val = quo_q[RATE_W-1:0];
	end

	assign refresh_hit = (accum_q >= {1'b0, period_q});
	assign rate_pick   = refresh_hit ? rate_val : lat_rate_q;
	assign out_free    = !out_vld_q || stats.ready;

	// Delta ring: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en)
			ring_mem[slot_q] <= delta_q;
		if (rd_en)
			rd_data_s1 <= ring_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			period_q     <= PERIOD_RESET;
			thresh_q     <= THRESH_RESET;
			prev_stamp_q <= '0;
			primed_q     <= 1'b0;
			delta_q      <= '0;
			slot_q       <= '0;
			sum_q        <= '0;
			accum_q      <= '0;
			lat_rate_q   <= '0;
			lat_max_q    <= '0;
			lat_min_q    <= '0;
			ring_vld_q   <= '0;
			rd_vld_s1    <= 1'b0;
			scan_idx_q   <= '0;
			scan_min_q   <= '0;
			scan_max_q   <= '0;
			divisor_q    <= '0;
			rem_q        <= '0;
			quo_q        <= '0;
			div_cnt_q    <= '0;
			out_vld_q    <= 1'b0;
			out_rate_q   <= '0;
			out_max_q    <= '0;
			out_min_q    <= '0;
			out_good_q   <= 1'b0;
			out_refr_q   <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					REG_REFRESH_PERIOD: period_q <= cfg.data[PERIOD_W-1:0];
					REG_GOOD_THRESHOLD: thresh_q <= cfg.data[THRESH_W-1:0];
					default: ;
				endcase
			end

			if (out_vld_q && stats.ready)
				out_vld_q <= 1'b0;

			if (rd_en)
				rd_vld_s1 <= ring_vld_q[rd_addr];

			// divider runs in the background once loaded
			if (div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - 1'b1;
				quo_q     <= {quo_q[DIV_W-2:0], div_take};
				rem_q     <= div_take ? SUM_W'(div_shift - {1'b0, divisor_q})
				                      : div_shift[SUM_W-1:0];
			end

			unique case (state_q)
				ST_IDLE: begin
					if (stamp_fire) begin
						delta_q      <= new_delta;
						prev_stamp_q <= stamp.timestamp_us;
						primed_q     <= 1'b1;
						state_q      <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					// old entry is on the read port now
					sum_q              <= sum_next;
					ring_vld_q[slot_q] <= 1'b1;
					slot_q  <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
					accum_q <= accum_q + ACCUM_W'(delta_q);
					// load divider with the new sum
					divisor_q  <= sum_next;
					rem_q      <= '0;
					quo_q      <= RATE_DIVIDEND[DIV_W-1:0];
					div_cnt_q  <= DIV_CNT_W'(DIV_W);
					scan_idx_q <= '0;
					state_q    <= ST_SCAN;
				end
				ST_SCAN: begin
					// read issued at idx, data consumed in the next cycle
					if (scan_idx_q != '0) begin
						if (scan_idx_q == SCAN_W'(1)) begin
							scan_min_q <= scan_val;
							scan_max_q <= scan_val;
						end else begin
							if (scan_val < scan_min_q)
								scan_min_q <= scan_val;
							if (scan_val > scan_max_q)
								scan_max_q <= scan_val;
						end
					end
					if (scan_idx_q == SCAN_W'(WINDOW))
						state_q <= ST_DIV_WAIT;
					else
						scan_idx_q <= scan_idx_q + 1'b1;
				end
				ST_DIV_WAIT: begin
					if (div_cnt_q == '0)
						state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						if (refresh_hit) begin
							accum_q    <= '0;
							lat_rate_q <= rate_val;
							lat_max_q  <= scan_max_q;
							lat_min_q  <= scan_min_q;
							out_max_q  <= scan_max_q;
							out_min_q  <= scan_min_q;
						end else begin
							out_max_q <= lat_max_q;
							out_min_q <= lat_min_q;
						end
						out_rate_q <= rate_pick;
						out_good_q <= (rate_pick >= {thresh_q, {FRAC_W{1'b0}}});
						out_refr_q <= refresh_hit;
						out_vld_q  <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
